### hw/rtl/value_scaled_pointer_velocity_top_defines.svh
// Assertion macros shared by the pointer velocity block.
// Both macros use the clock clk of the module that uses them; VSPV_ASSERT also uses arst_n.
`ifndef VALUE_SCALED_POINTER_VELOCITY_TOP_DEFINES_SVH
`define VALUE_SCALED_POINTER_VELOCITY_TOP_DEFINES_SVH
`ifndef SYNTH
`define VSPV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VSPV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VSPV_ASSERT(lbl, prop, msg)
`define VSPV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hw/rtl/vspv_pkg.sv
// ----------------------------------------------------------------------------
// vspv_pkg
// Types, codes and helper functions of the value-scaled pointer velocity block.
// ----------------------------------------------------------------------------
package vspv_pkg;

	// Command codes of an input transaction.
	localparam logic [1:0] CMD_PRESS   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_VALUE_LOW  = 2'd0;
	localparam logic [1:0] REG_VALUE_HIGH = 2'd1;
	localparam logic [1:0] REG_SPEED_LOW  = 2'd2;
	localparam logic [1:0] REG_SPEED_HIGH = 2'd3;

	localparam logic signed [15:0] VALUE_LOW_RST  = 16'sd0;
	localparam logic signed [15:0] VALUE_HIGH_RST = 16'sd100;
	localparam logic signed [15:0] SPEED_LOW_RST  = 16'sd200;
	localparam logic signed [15:0] SPEED_HIGH_RST = 16'sd1800;

	// Divider geometry: magnitude of a 17x17 signed product over a 16-bit divisor.
	localparam int DVD_W = 34;
	localparam int DSR_W = 16;
	localparam int CNT_W = $clog2(DVD_W);

	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV,
		ST_FIN,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	function automatic sign_t sign_code(input logic signed [15:0] d);
		sign_t s;
		if (d == 16'sd0) begin
			s = SGN_ZERO;
		end else if (d[15]) begin
			s = SGN_NEG;
		end else begin
			s = SGN_POS;
		end
		return s;
	endfunction

	function automatic logic [15:0] axis_move(input sign_t s, input logic [15:0] p);
		logic [15:0] m;
		case (s)
			SGN_POS: m = p;
			SGN_NEG: m = 16'd0 - p;
			default: m = 16'd0;
		endcase
		return m;
	endfunction

endpackage

### hw/rtl/vspv_in_if.sv
// ----------------------------------------------------------------------------
// vspv_in_if
// Input channel: one command transaction with direction, value and key data.
// ----------------------------------------------------------------------------
interface vspv_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic signed [31:0] stored_value;
	logic [14:0]        key_position;
	logic [7:0]         layer_number;

	modport source (output valid, cmd, dir_x, dir_y, stored_value, key_position,
		layer_number, input ready);
	modport sink (input valid, cmd, dir_x, dir_y, stored_value, key_position,
		layer_number, output ready);
endinterface

### hw/rtl/vspv_out_if.sv
// ----------------------------------------------------------------------------
// vspv_out_if
// Result channel: one move press or release transaction.
// ----------------------------------------------------------------------------
interface vspv_out_if;
	logic               valid;
	logic               ready;
	logic               is_press;
	logic signed [15:0] move_x;
	logic signed [15:0] move_y;
	logic [14:0]        out_position;
	logic [7:0]         out_layer;
	logic               last;

	modport source (output valid, is_press, move_x, move_y, out_position, out_layer,
		last, input ready);
	modport sink (input valid, is_press, move_x, move_y, out_position, out_layer,
		last, output ready);
endinterface

### hw/rtl/vspv_cfg_if.sv
// ----------------------------------------------------------------------------
// vspv_cfg_if
// Configuration write channel: register index and 16-bit write data.
// ----------------------------------------------------------------------------
interface vspv_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [15:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

### hw/rtl/vspv_div.sv
// ----------------------------------------------------------------------------
// vspv_div
// Unsigned restoring divider, one quotient bit per cycle through one subtractor.
// ----------------------------------------------------------------------------
`include "value_scaled_pointer_velocity_top_defines.svh"

module vspv_div import vspv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;

	logic [DSR_W:0]   shifted;
	logic [DSR_W+1:0] diff;
	logic             fits;

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits    = !diff[DSR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

	`VSPV_ASSERT(a_start_busy, start |=> busy_q, "divider not busy after start")
	`VSPV_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a running division")

endmodule

### hw/rtl/value_scaled_pointer_velocity_top.sv
// A press or tick result is registered after states ST_MUL, ST_DIV_GO, ST_DIV
// and ST_FIN, a release result from ST_EMIT0; the 34-step divider dominates.
// Throughput: commands are taken only in ST_IDLE, so a press, active tick or
// active release ends before the next is taken; anything else every cycle; a
// result held by a stalled output adds the cycles it waits.
// Reset: arst_n clears sequencer, pointer and output-valid state and loads register reset values; ready at once.
// ----------------------------------------------------------------------------
// value_scaled_pointer_velocity_top
// Maps a stored value onto a pointer speed and issues move press and release
// transactions for a held direction key, under a small sequencer.
// ----------------------------------------------------------------------------
`include "value_scaled_pointer_velocity_top_defines.svh"

module value_scaled_pointer_velocity_top import vspv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	vspv_in_if.sink    item_in,
	vspv_out_if.source result_out,
	vspv_cfg_if.sink   cfg
);

	state_t state_q, state_d;

	// Configuration registers.
	logic signed [15:0] vlow_q, vhigh_q, slow_q, shigh_q;

	// Pointer state.
	logic        active_q;
	sign_t       sign_x_q, sign_y_q;
	logic [15:0] cur_x_q, cur_y_q;
	logic [14:0] held_pos_q;
	logic [7:0]  held_lay_q;

	// Latched input transaction.
	logic [1:0]         cmd_q;
	logic signed [31:0] val_q;
	logic [14:0]        pos_q;
	logic [7:0]         lay_q;
	sign_t              new_sx_q, new_sy_q;

	// Arithmetic registers.
	logic [DVD_W-1:0] num_mag_q;
	logic [DSR_W-1:0] den_mag_q;
	logic             qneg_q;
	logic [15:0]      nx_q, ny_q;

	// Output register.
	logic        ov_q;
	logic        o_press_q, o_last_q;
	logic [15:0] o_x_q, o_y_q;
	logic [14:0] o_pos_q;
	logic [7:0]  o_lay_q;

	logic             in_acc;
	logic             div_start, div_done;
	logic [DVD_W-1:0] quo;
	logic             emit_ok, emit_ld;

	vspv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag_q),
		.divisor  (den_mag_q),
		.done     (div_done),
		.quotient (quo)
	);

	// Clamp the value and form the scaled product.
	logic signed [15:0] vcl;
	logic signed [16:0] dv, ds, den;
	logic signed [33:0] prod;

	always_comb begin
		if (val_q < 32'(vlow_q)) begin
			vcl = vlow_q;
		end else if (val_q > 32'(vhigh_q)) begin
			vcl = vhigh_q;
		end else begin
			vcl = val_q[15:0];
		end
		dv   = 17'(vcl) - 17'(vlow_q);
		ds   = 17'(shigh_q) - 17'(slow_q);
		den  = 17'(vhigh_q) - 17'(vlow_q);
		prod = 34'(dv) * 34'(ds);
	end

	// Signed quotient, offset, final clamp and per-axis moves.
	logic signed [34:0] qs;
	logic signed [35:0] vel;
	logic signed [15:0] vel16;
	sign_t              use_sx, use_sy;
	logic [15:0]        mx, my;

	always_comb begin
		qs  = qneg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		vel = 36'(slow_q) + 36'(qs);
		if (vlow_q == vhigh_q) begin
			vel16 = shigh_q;
		end else if (vel < 36'(slow_q)) begin
			vel16 = slow_q;
		end else if (vel > 36'(shigh_q)) begin
			vel16 = shigh_q;
		end else begin
			vel16 = vel[15:0];
		end
		use_sx = (cmd_q == CMD_PRESS) ? new_sx_q : sign_x_q;
		use_sy = (cmd_q == CMD_PRESS) ? new_sy_q : sign_y_q;
		mx     = axis_move(use_sx, vel16);
		my     = axis_move(use_sy, vel16);
	end

	assign in_acc  = item_in.valid && item_in.ready;
	assign emit_ok = !ov_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		item_in.ready = 1'b0;
		div_start     = 1'b0;
		emit_ld       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_in.ready = 1'b1;
				if (item_in.valid) begin
					case (item_in.cmd)
						CMD_PRESS:   state_d = ST_MUL;
						CMD_RELEASE: state_d = active_q ? ST_EMIT0 : ST_IDLE;
						CMD_TICK:    state_d = active_q ? ST_MUL : ST_IDLE;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (cmd_q == CMD_TICK && mx == cur_x_q && my == cur_y_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EMIT0;
				end
			end
			ST_EMIT0: begin
				if (emit_ok) begin
					emit_ld = 1'b1;
					state_d = (cmd_q == CMD_TICK) ? ST_EMIT1 : ST_IDLE;
				end
			end
			ST_EMIT1: begin
				if (emit_ok) begin
					emit_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration writes must arrive only while the block is idle; the block itself does not enforce it.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlow_q  <= VALUE_LOW_RST;
			vhigh_q <= VALUE_HIGH_RST;
			slow_q  <= SPEED_LOW_RST;
			shigh_q <= SPEED_HIGH_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				REG_VALUE_LOW:  vlow_q  <= cfg.data;
				REG_VALUE_HIGH: vhigh_q <= cfg.data;
				REG_SPEED_LOW:  slow_q  <= cfg.data;
				REG_SPEED_HIGH: shigh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			sign_x_q   <= SGN_ZERO;
			sign_y_q   <= SGN_ZERO;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			held_pos_q <= '0;
			held_lay_q <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (state_q == ST_FIN && cmd_q == CMD_PRESS) begin
				active_q   <= 1'b1;
				sign_x_q   <= new_sx_q;
				sign_y_q   <= new_sy_q;
				held_pos_q <= pos_q;
				held_lay_q <= lay_q;
				cur_x_q    <= mx;
				cur_y_q    <= my;
			end
			if (state_q == ST_EMIT0 && emit_ld) begin
				if (cmd_q == CMD_RELEASE) begin
					active_q <= 1'b0;
				end
				// A tick commits the new move once the release of the old one is out.
				if (cmd_q == CMD_TICK) begin
					cur_x_q <= nx_q;
					cur_y_q <= ny_q;
				end
			end
			if (emit_ld) begin
				ov_q <= 1'b1;
			end else if (result_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= item_in.cmd;
			val_q    <= item_in.stored_value;
			pos_q    <= item_in.key_position;
			lay_q    <= item_in.layer_number;
			new_sx_q <= sign_code(item_in.dir_x);
			new_sy_q <= sign_code(item_in.dir_y);
		end
		if (state_q == ST_MUL) begin
			num_mag_q <= prod[33] ? DVD_W'(-prod) : DVD_W'(prod);
			den_mag_q <= den[16] ? DSR_W'(-den) : DSR_W'(den);
			qneg_q    <= prod[33] ^ den[16];
		end
		if (state_q == ST_FIN) begin
			nx_q <= mx;
			ny_q <= my;
		end
		if (emit_ld) begin
			o_press_q <= (state_q == ST_EMIT1) || (cmd_q == CMD_PRESS);
			o_last_q  <= (state_q == ST_EMIT1) || (cmd_q != CMD_TICK);
			o_x_q     <= cur_x_q;
			o_y_q     <= cur_y_q;
			o_pos_q   <= (cmd_q == CMD_TICK) ? held_pos_q : pos_q;
			o_lay_q   <= (cmd_q == CMD_TICK) ? held_lay_q : lay_q;
		end
	end

	assign result_out.valid        = ov_q;
	assign result_out.is_press     = o_press_q;
	assign result_out.move_x       = o_x_q;
	assign result_out.move_y       = o_y_q;
	assign result_out.out_position = o_pos_q;
	assign result_out.out_layer    = o_lay_q;
	assign result_out.last         = o_last_q;

	`VSPV_ASSERT(a_done_in_div, div_done |-> state_q == ST_DIV, "division ended outside its wait state")
	`VSPV_ASSERT(a_no_second_early, in_acc |=> state_q != ST_EMIT1, "second result without first")
	`VSPV_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> state_q == ST_IDLE, "sequencer busy in reset")

endmodule
